[hw/rtl/bpa_pkg.sv]
`default_nettype none

package bpa_pkg;

  // Pool geometry.
  localparam int POOL_BLOCKS = 256;
  localparam int AW          = $clog2(POOL_BLOCKS);      // block index width
  localparam int CW          = $clog2(POOL_BLOCKS + 1);  // block count width
  localparam int SUM_W       = CW + 1;                   // index plus count

  // Field and register widths.
  localparam int FUNC_W   = 2;
  localparam int SIZE_W   = 21;
  localparam int OFF_W    = 20;
  localparam int BB_W     = 13;
  localparam int BB_MAX   = 4096;
  localparam int BB_RESET = 8;

  // Divider: dividend is size plus block bytes minus one.
  localparam int DIV_W  = SIZE_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // Block count times block bytes.
  localparam int PW    = CW + BB_W;
  localparam int CMP_W = (PW > OFF_W) ? PW : OFF_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_PROBE = 2'd2,
    FUNC_OWN   = 2'd3
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  offset_in;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] offset_out;
  } rsp_t;

  typedef enum logic {
    DIV_CAP = 1'b0,
    DIV_OFF = 1'b1
  } div_sel_e;

  typedef enum logic [1:0] {
    MUL_NB    = 2'd0,
    MUL_START = 2'd1,
    MUL_BUMP  = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    WR_CLEAR = 2'd0,
    WR_ALLOC = 2'd1,
    WR_FREE  = 2'd2
  } wr_sel_e;

  typedef enum logic [1:0] {
    OK_NONE  = 2'd0,
    OK_PROBE = 2'd1,
    OK_OWN   = 2'd2
  } ok_src_e;

  typedef enum logic [4:0] {
    ST_CLR_LOAD,
    ST_CLR_RUN,
    ST_IDLE,
    ST_DIV_CAP,
    ST_WAIT_CAP,
    ST_ROUTE,
    ST_SCAN,
    ST_PROBE_END,
    ST_DECIDE,
    ST_MUL_RES,
    ST_WRITE,
    ST_DIV_OFF,
    ST_WAIT_OFF,
    ST_CHECK_FREE,
    ST_MUL_FREE,
    ST_FREE_BUMP,
    ST_MUL_OWN,
    ST_OWN_END,
    ST_RESP
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_req;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_load;
    logic     start_load;
    logic     scan_init;
    logic     scan_run;
    logic     decide;
    logic     free_apply;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     wr_load;
    wr_sel_e  wr_sel;
    logic     wr_run;
    ok_src_e  ok_set;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  div_busy;
    logic  cap_ok;
    logic  scan_last;
    logic  alloc_ok;
    logic  free_ok;
    logic  wr_done;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/block_pool_allocator.sv]
// Channel   Direction  Handshake                    Payload
// request   in         start / busy                 req_i (func, size_bytes, offset_in)
// result    out        done_o, one-cycle strobe     rsp_o (ok, offset_out)
// config    in         cfg_valid_i / cfg_ready_o    cfg_data_i (block_bytes)
//
// A request is taken when start is high and busy is low; busy stays high
// until the result strobe has gone by. Allocate and probe run a 22-step
// divider, then scan one bitmap entry per cycle through the map RAM read
// port; a granted allocate then writes its blocks to the map. Free runs the
// divider twice, then writes its blocks; ownership runs the divider once.
// After reset the map is cleared one entry per cycle with busy high;
// configuration transfers are taken at any time.
// The receiver cannot stall: each result is valid for the strobe cycle only.
`default_nettype none

module block_pool_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  bpa_pkg::req_t            req_i,
  output logic                     done_o,
  output bpa_pkg::rsp_t            rsp_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bpa_pkg::BB_W-1:0] cfg_data_i
);

  bpa_pkg::ctrl_cmd_t  cmd;
  bpa_pkg::dp_status_t status;

  // The block size register accepts a transfer in every cycle.
  assign cfg_ready_o = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  bpa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

[hw/rtl/bpa_ram.sv]
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/bpa_div.sv]
`default_nettype none

module bpa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bpa_pkg::DIV_W-1:0] num_i,
  input  logic [bpa_pkg::BB_W-1:0]  den_i,
  output logic                      busy_o,
  output logic [bpa_pkg::DIV_W-1:0] quo_o
);

  localparam int DIV_W  = bpa_pkg::DIV_W;
  localparam int BB_W   = bpa_pkg::BB_W;
  localparam int DCNT_W = bpa_pkg::DCNT_W;

  logic              busy_q, busy_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [BB_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [BB_W:0]     trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle. The caller must hold the
  // divisor stable for the whole operation; the divider does not enforce this.
  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    fits   = (trial >= {1'b0, den_i});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIV_W);
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? BB_W'(trial - {1'b0, den_i}) : trial[BB_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

[hw/rtl/bpa_dp.sv]
`default_nettype none

module bpa_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bpa_pkg::req_t            req_i,
  input  logic                     cfg_we_i,
  input  logic [bpa_pkg::BB_W-1:0] cfg_data_i,
  input  bpa_pkg::ctrl_cmd_t       cmd_i,
  output bpa_pkg::dp_status_t      status_o,
  output bpa_pkg::rsp_t            rsp_o
);

  localparam int NB     = bpa_pkg::POOL_BLOCKS;
  localparam int AW     = bpa_pkg::AW;
  localparam int CW     = bpa_pkg::CW;
  localparam int SUM_W  = bpa_pkg::SUM_W;
  localparam int SIZE_W = bpa_pkg::SIZE_W;
  localparam int OFF_W  = bpa_pkg::OFF_W;
  localparam int BB_W   = bpa_pkg::BB_W;
  localparam int DIV_W  = bpa_pkg::DIV_W;
  localparam int PW     = bpa_pkg::PW;
  localparam int CMP_W  = bpa_pkg::CMP_W;

  // Request and configuration.
  logic [BB_W-1:0]   cfg_q;
  logic [BB_W-1:0]   bb_eff;
  bpa_pkg::func_e    func_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  offs_q;

  // Division results.
  logic [DIV_W-1:0] cap_q, cap_d;
  logic [OFF_W-1:0] start_q, start_d;
  logic [CW-1:0]    cap_c;

  // Bitmap scan.
  logic [CW-1:0] addr_q, addr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q;
  logic [CW-1:0] run_q, run_d, run_inc;
  logic          ff_found_q, ff_found_d;
  logic [AW-1:0] ff_start_q, ff_start_d;
  logic          bump_bad_q, bump_bad_d;
  logic          issue;

  // Bump index and write pass.
  logic [CW-1:0]    bump_q, bump_d;
  logic [SUM_W-1:0] idx_w, bump_w, bump_end;
  logic             bump_fit;
  logic [AW-1:0]    wr_addr_q, wr_addr_d;
  logic [CW-1:0]    wr_left_q, wr_left_d;
  logic             wr_val_q, wr_val_d;

  // Multiplier and result.
  logic [CW-1:0]    mul_a;
  logic [PW-1:0]    prod_q;
  logic [CMP_W-1:0] prod_ext, offs_ext;
  logic             ok_q, ok_d;
  logic             alloc_ok, free_ok;
  logic [DIV_W-1:0] start_w;

  // Divider hookup.
  logic             div_busy;
  logic [DIV_W-1:0] div_num, div_quo;

  // Bitmap memory.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  // Effective block size: zero acts as one, large values clamp.
  always_comb begin
    if (cfg_q == '0) begin
      bb_eff = BB_W'(1);
    end else if (cfg_q > BB_W'(bpa_pkg::BB_MAX)) begin
      bb_eff = BB_W'(bpa_pkg::BB_MAX);
    end else begin
      bb_eff = cfg_q;
    end
  end

  // Dividend for the block count or for the first block of a free.
  assign div_num = (cmd_i.div_sel == bpa_pkg::DIV_CAP) ?
                   (DIV_W'(size_q) + DIV_W'(bb_eff) - DIV_W'(1)) : DIV_W'(offs_q);

  bpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (bb_eff),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  bpa_ram #(
    .WIDTH (1),
    .DEPTH (NB)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Derived values.
  assign cap_c    = cap_q[CW-1:0];
  assign idx_w    = SUM_W'(rd_idx_q);
  assign bump_w   = SUM_W'(bump_q);
  assign bump_end = bump_w + SUM_W'(cap_c);
  assign bump_fit = !bump_bad_q && (bump_end <= SUM_W'(NB));
  assign alloc_ok = bump_fit || ff_found_q;
  assign start_w  = DIV_W'(start_q);
  assign free_ok  = (cap_q != '0) && (start_w <= DIV_W'(NB)) &&
                    (cap_q <= DIV_W'(NB) - start_w);
  assign issue    = cmd_i.scan_run && (addr_q != CW'(NB));
  assign run_inc  = run_q + CW'(1);
  assign prod_ext = CMP_W'(prod_q);
  assign offs_ext = CMP_W'(offs_q);

  // Multiplier operand.
  always_comb begin
    case (cmd_i.mul_sel)
      bpa_pkg::MUL_NB:    mul_a = CW'(NB);
      bpa_pkg::MUL_START: mul_a = CW'(start_q[AW-1:0]);
      bpa_pkg::MUL_BUMP:  mul_a = bump_q - cap_c;
      default:            mul_a = '0;
    endcase
  end

  // Scan, decision, write pass and result flag.
  always_comb begin
    cap_d      = cap_q;
    start_d    = start_q;
    addr_d     = addr_q;
    rd_vld_d   = issue;
    run_d      = run_q;
    ff_found_d = ff_found_q;
    ff_start_d = ff_start_q;
    bump_bad_d = bump_bad_q;
    bump_d     = bump_q;
    wr_addr_d  = wr_addr_q;
    wr_left_d  = wr_left_q;
    wr_val_d   = wr_val_q;
    ok_d       = ok_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_addr_q;
    ram_wdata  = wr_val_q;

    if (cmd_i.cap_load) begin
      cap_d = div_quo;
    end
    if (cmd_i.start_load) begin
      start_d = div_quo[OFF_W-1:0];
    end

    // Walk the map one entry per cycle; the read data is registered in the map RAM.
    if (issue) begin
      addr_d = addr_q + CW'(1);
    end
    if (rd_vld_q) begin
      if (ram_rdata) begin
        run_d = run_inc;
        if (!ff_found_q && (run_inc == cap_c)) begin
          ff_found_d = 1'b1;
          ff_start_d = AW'(idx_w + SUM_W'(1) - SUM_W'(cap_c));
        end
      end else begin
        run_d = '0;
        if ((idx_w >= bump_w) && (idx_w < bump_end)) begin
          bump_bad_d = 1'b1;
        end
      end
    end
    if (cmd_i.scan_init) begin
      addr_d     = '0;
      rd_vld_d   = 1'b0;
      run_d      = '0;
      ff_found_d = 1'b0;
      bump_bad_d = 1'b0;
    end

    // Allocation: prefer the bump index, else the first fit.
    if (cmd_i.decide) begin
      ok_d = alloc_ok;
      if (bump_fit) begin
        start_d = OFF_W'(bump_q);
        bump_d  = CW'(bump_end);
      end else begin
        start_d = OFF_W'(ff_start_q);
      end
    end

    // Free: pull the bump index back when the region ends at it.
    if (cmd_i.free_apply) begin
      ok_d = 1'b1;
      if ((bump_q >= cap_c) && (offs_ext == prod_ext)) begin
        bump_d = bump_q - cap_c;
      end
    end

    case (cmd_i.ok_set)
      bpa_pkg::OK_PROBE: ok_d = ff_found_q;
      bpa_pkg::OK_OWN:   ok_d = (offs_ext < prod_ext);
      default:           ;
    endcase
    if (cmd_i.load_req) begin
      ok_d = 1'b0;
    end

    // Write pass over a run of map entries.
    if (cmd_i.wr_load) begin
      case (cmd_i.wr_sel)
        bpa_pkg::WR_CLEAR: begin
          wr_addr_d = '0;
          wr_left_d = CW'(NB);
          wr_val_d  = 1'b1;
        end
        bpa_pkg::WR_ALLOC: begin
          wr_addr_d = start_q[AW-1:0];
          wr_left_d = cap_c;
          wr_val_d  = 1'b0;
        end
        default: begin
          wr_addr_d = start_q[AW-1:0];
          wr_left_d = cap_c;
          wr_val_d  = 1'b1;
        end
      endcase
    end else if (cmd_i.wr_run && (wr_left_q != '0)) begin
      ram_we    = 1'b1;
      wr_addr_d = wr_addr_q + AW'(1);
      wr_left_d = wr_left_q - CW'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= BB_W'(bpa_pkg::BB_RESET);
      bump_q     <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      ff_found_q <= 1'b0;
      wr_addr_q  <= '0;
      wr_left_q  <= '0;
      ok_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      bump_q     <= bump_d;
      addr_q     <= addr_d;
      rd_vld_q   <= rd_vld_d;
      ff_found_q <= ff_found_d;
      wr_addr_q  <= wr_addr_d;
      wr_left_q  <= wr_left_d;
      ok_q       <= ok_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q <= req_i.func;
      size_q <= req_i.size_bytes;
      offs_q <= req_i.offset_in;
    end
    if (cmd_i.mul_go) begin
      prod_q <= PW'(mul_a) * PW'(bb_eff);
    end
    cap_q      <= cap_d;
    start_q    <= start_d;
    rd_idx_q   <= addr_q[AW-1:0];
    run_q      <= run_d;
    ff_start_q <= ff_start_d;
    bump_bad_q <= bump_bad_d;
    wr_val_q   <= wr_val_d;
  end

  // Status and result.
  assign status_o.func      = func_q;
  assign status_o.div_busy  = div_busy;
  assign status_o.cap_ok    = (cap_q != '0) && (cap_q <= DIV_W'(NB));
  assign status_o.scan_last = rd_vld_q && (rd_idx_q == AW'(NB - 1));
  assign status_o.alloc_ok  = alloc_ok;
  assign status_o.free_ok   = free_ok;
  assign status_o.wr_done   = (wr_left_q == '0);

  assign rsp_o.ok         = ok_q;
  assign rsp_o.offset_out = ((func_q == bpa_pkg::FUNC_ALLOC) && ok_q) ?
                            prod_ext[OFF_W-1:0] : '0;

  // The bump index never passes the end of the pool.
  a_bump_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= CW'(NB))
    else $error("bump index beyond pool");

  // A write pass never runs past the last block.
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_left_q != '0) |-> (SUM_W'(wr_addr_q) + SUM_W'(wr_left_q) <= SUM_W'(NB)))
    else $error("write pass runs past pool end");

endmodule

`default_nettype wire

[hw/rtl/bpa_ctrl.sv]
`default_nettype none

module bpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bpa_pkg::dp_status_t status_i,
  output bpa_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  bpa_pkg::ctrl_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::ST_CLR_LOAD: state_d = bpa_pkg::ST_CLR_RUN;
      bpa_pkg::ST_CLR_RUN: begin
        if (status_i.wr_done) state_d = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_IDLE: begin
        if (start_i) state_d = bpa_pkg::ST_DIV_CAP;
      end
      bpa_pkg::ST_DIV_CAP: state_d = bpa_pkg::ST_WAIT_CAP;
      bpa_pkg::ST_WAIT_CAP: begin
        if (!status_i.div_busy) state_d = bpa_pkg::ST_ROUTE;
      end
      bpa_pkg::ST_ROUTE: begin
        case (status_i.func)
          bpa_pkg::FUNC_ALLOC,
          bpa_pkg::FUNC_PROBE: begin
            state_d = status_i.cap_ok ? bpa_pkg::ST_SCAN : bpa_pkg::ST_RESP;
          end
          bpa_pkg::FUNC_FREE: state_d = bpa_pkg::ST_DIV_OFF;
          default:            state_d = bpa_pkg::ST_MUL_OWN;
        endcase
      end
      bpa_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = (status_i.func == bpa_pkg::FUNC_ALLOC) ?
                    bpa_pkg::ST_DECIDE : bpa_pkg::ST_PROBE_END;
        end
      end
      bpa_pkg::ST_PROBE_END: state_d = bpa_pkg::ST_RESP;
      bpa_pkg::ST_DECIDE: begin
        state_d = status_i.alloc_ok ? bpa_pkg::ST_MUL_RES : bpa_pkg::ST_RESP;
      end
      bpa_pkg::ST_MUL_RES: state_d = bpa_pkg::ST_WRITE;
      bpa_pkg::ST_WRITE: begin
        if (status_i.wr_done) state_d = bpa_pkg::ST_RESP;
      end
      bpa_pkg::ST_DIV_OFF: state_d = bpa_pkg::ST_WAIT_OFF;
      bpa_pkg::ST_WAIT_OFF: begin
        if (!status_i.div_busy) state_d = bpa_pkg::ST_CHECK_FREE;
      end
      bpa_pkg::ST_CHECK_FREE: begin
        state_d = status_i.free_ok ? bpa_pkg::ST_MUL_FREE : bpa_pkg::ST_RESP;
      end
      bpa_pkg::ST_MUL_FREE:  state_d = bpa_pkg::ST_FREE_BUMP;
      bpa_pkg::ST_FREE_BUMP: state_d = bpa_pkg::ST_WRITE;
      bpa_pkg::ST_MUL_OWN:   state_d = bpa_pkg::ST_OWN_END;
      bpa_pkg::ST_OWN_END:   state_d = bpa_pkg::ST_RESP;
      bpa_pkg::ST_RESP:      state_d = bpa_pkg::ST_IDLE;
      default:               state_d = bpa_pkg::ST_IDLE;
    endcase
  end

  // Commands for each state.
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != bpa_pkg::ST_IDLE);
    done_o = (state_q == bpa_pkg::ST_RESP);
    case (state_q)
      bpa_pkg::ST_CLR_LOAD: begin
        cmd_o.wr_load = 1'b1;
        cmd_o.wr_sel  = bpa_pkg::WR_CLEAR;
      end
      bpa_pkg::ST_CLR_RUN: cmd_o.wr_run = 1'b1;
      bpa_pkg::ST_IDLE:    cmd_o.load_req = start_i;
      bpa_pkg::ST_DIV_CAP: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bpa_pkg::DIV_CAP;
      end
      bpa_pkg::ST_WAIT_CAP: cmd_o.cap_load = !status_i.div_busy;
      bpa_pkg::ST_ROUTE:    cmd_o.scan_init = 1'b1;
      bpa_pkg::ST_SCAN:     cmd_o.scan_run = 1'b1;
      bpa_pkg::ST_PROBE_END: cmd_o.ok_set = bpa_pkg::OK_PROBE;
      bpa_pkg::ST_DECIDE:   cmd_o.decide = 1'b1;
      bpa_pkg::ST_MUL_RES: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = bpa_pkg::MUL_START;
        cmd_o.wr_load = 1'b1;
        cmd_o.wr_sel  = bpa_pkg::WR_ALLOC;
      end
      bpa_pkg::ST_WRITE: cmd_o.wr_run = 1'b1;
      bpa_pkg::ST_DIV_OFF: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = bpa_pkg::DIV_OFF;
      end
      bpa_pkg::ST_WAIT_OFF: cmd_o.start_load = !status_i.div_busy;
      bpa_pkg::ST_MUL_FREE: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = bpa_pkg::MUL_BUMP;
        cmd_o.wr_load = 1'b1;
        cmd_o.wr_sel  = bpa_pkg::WR_FREE;
      end
      bpa_pkg::ST_FREE_BUMP: cmd_o.free_apply = 1'b1;
      bpa_pkg::ST_MUL_OWN: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = bpa_pkg::MUL_NB;
      end
      bpa_pkg::ST_OWN_END: cmd_o.ok_set = bpa_pkg::OK_OWN;
      default: ;
    endcase
  end

  // State register; reset starts the map clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::ST_CLR_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // Each request gives a single one-cycle result strobe.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result strobe longer than one cycle");

  // The map is only scanned once the divider has finished.
  a_scan_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpa_pkg::ST_SCAN) |-> !status_i.div_busy)
    else $error("scan while divider busy");

endmodule

`default_nettype wire

[tb/block_pool_allocator_tb.sv]
`default_nettype none

module block_pool_allocator_tb;

  // Shadow of the allocator: free bitmap, bump index and block size.
  class alloc_scoreboard;
    bit [bpa_pkg::POOL_BLOCKS-1:0] free_map;
    longint unsigned               bump_idx;
    bit [bpa_pkg::BB_W-1:0]        block_bytes;
    bpa_pkg::rsp_t                 expected_q[$];
    int unsigned                   errors;
    // Region granted by the most recent allocate, for the stimulus.
    bit                            granted;
    int unsigned                   granted_block;
    int unsigned                   granted_count;

    function new();
      free_map    = '1;
      bump_idx    = 0;
      block_bytes = bpa_pkg::BB_RESET;
      errors      = 0;
      granted     = 1'b0;
    endfunction

    // Block size as the pool uses it, clamped to 1..BB_MAX.
    function longint unsigned unit_bytes();
      if (block_bytes == 0) return 1;
      if (block_bytes > bpa_pkg::BB_MAX) return bpa_pkg::BB_MAX;
      return block_bytes;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit run_is_free(longint unsigned first, longint unsigned cnt);
      longint unsigned k;
      if (first > bpa_pkg::POOL_BLOCKS || cnt > bpa_pkg::POOL_BLOCKS - first) return 1'b0;
      for (k = first; k < first + cnt; k++) begin
        if (!free_map[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void mark_blocks(longint unsigned first, longint unsigned cnt, bit value);
      longint unsigned k;
      for (k = first; k < first + cnt && k < bpa_pkg::POOL_BLOCKS; k++) begin
        free_map[k] = value;
      end
    endfunction

    // Lowest start of a free run of cnt blocks.
    function bit lowest_fit(longint unsigned cnt, output longint unsigned first);
      longint unsigned run;
      int              i;
      run   = 0;
      first = 0;
      if (cnt == 0 || cnt > bpa_pkg::POOL_BLOCKS) return 1'b0;
      for (i = 0; i < bpa_pkg::POOL_BLOCKS; i++) begin
        run = free_map[i] ? run + 1 : 0;
        if (run == cnt) begin
          first = i + 1 - cnt;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Apply one accepted request and queue the response it must give.
    function void note_request(bpa_pkg::req_t r);
      longint unsigned bb;
      longint unsigned cnt;
      longint unsigned first;
      longint unsigned offs;
      longint unsigned size;
      bpa_pkg::rsp_t   exp_rsp;
      bb      = unit_bytes();
      size    = r.size_bytes;
      offs    = r.offset_in;
      cnt     = (size + bb - 1) / bb;
      first   = 0;
      exp_rsp = '0;
      granted = 1'b0;
      case (r.func)
        bpa_pkg::FUNC_ALLOC: begin
          if (cnt != 0 && cnt <= bpa_pkg::POOL_BLOCKS) begin
            if (run_is_free(bump_idx, cnt)) begin
              first    = bump_idx;
              bump_idx = first + cnt;
              granted  = 1'b1;
            end else if (lowest_fit(cnt, first)) begin
              granted = 1'b1;
            end
            if (granted) begin
              mark_blocks(first, cnt, 1'b0);
              exp_rsp.ok         = 1'b1;
              exp_rsp.offset_out = bpa_pkg::OFF_W'(first * bb);
              granted_block      = 32'(first);
              granted_count      = 32'(cnt);
            end
          end
        end
        bpa_pkg::FUNC_FREE: begin
          first = offs / bb;
          if (cnt != 0 && first <= bpa_pkg::POOL_BLOCKS &&
              cnt <= bpa_pkg::POOL_BLOCKS - first) begin
            // A region that ends exactly at the bump index pulls it back.
            if (bump_idx >= cnt && offs == (bump_idx - cnt) * bb) begin
              bump_idx = bump_idx - cnt;
            end
            mark_blocks(first, cnt, 1'b1);
            exp_rsp.ok = 1'b1;
          end
        end
        bpa_pkg::FUNC_PROBE: begin
          exp_rsp.ok = lowest_fit(cnt, first);
        end
        default: begin
          exp_rsp.ok = (offs < bpa_pkg::POOL_BLOCKS * bb);
        end
      endcase
      expected_q.push_back(exp_rsp);
    endfunction

    task report_error(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task check_result(bpa_pkg::rsp_t got);
      bpa_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        report_error("response with no request pending", got, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.ok !== want.ok) report_error("ok", got.ok, want.ok);
        if (got.offset_out !== want.offset_out) begin
          report_error("offset_out", got.offset_out, want.offset_out);
        end
      end
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  bpa_pkg::req_t            req_i;
  logic                     done_o;
  bpa_pkg::rsp_t            rsp_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [bpa_pkg::BB_W-1:0] cfg_data_i;

  alloc_scoreboard sb = new();
  bit              quiet;
  int unsigned     live_first[$];
  int unsigned     live_count[$];

  block_pool_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Every response strobe is one transfer; compare it with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_result(rsp_o);
  end

  // Hold a request until the allocator takes it.
  task automatic send_request(bpa_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
    if (r.func == bpa_pkg::FUNC_ALLOC && sb.granted) begin
      live_first.push_back(sb.granted_block);
      live_count.push_back(sb.granted_count);
    end
  endtask

  // Random sender idle time; long gaps land on any phase of the work.
  task automatic sender_gap();
    int unsigned n;
    n = 0;
    if (!quiet && $urandom_range(0, 99) < 21) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 700) : $urandom_range(1, 4);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop sending until every response is in and the allocator is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_block_bytes(logic [bpa_pkg::BB_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.block_bytes = value;
  endtask

  task automatic directed(bpa_pkg::func_e f, int unsigned size, int unsigned offs);
    bpa_pkg::req_t r;
    r.func       = f;
    r.size_bytes = bpa_pkg::SIZE_W'(size);
    r.offset_in  = bpa_pkg::OFF_W'(offs);
    send_request(r);
    sender_gap();
  endtask

  // Byte size covering nblk blocks, with a random short tail.
  function automatic logic [bpa_pkg::SIZE_W-1:0] bytes_of(int unsigned nblk);
    longint unsigned bb;
    longint unsigned s;
    bb = sb.unit_bytes();
    s  = nblk * bb - $urandom_range(0, bb - 1);
    if (s > 1048576) s = 1048576;
    return bpa_pkg::SIZE_W'(s);
  endfunction

  // Mostly small regions, now and then large or larger than the pool.
  function automatic int unsigned pick_blocks();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 6);
    if (p < 95) return $urandom_range(7, 40);
    return $urandom_range(41, 270);
  endfunction

  task automatic random_request();
    bpa_pkg::req_t   r;
    int unsigned     p;
    int unsigned     idx;
    longint unsigned bb;
    bb           = sb.unit_bytes();
    p            = $urandom_range(0, 99);
    r.func       = bpa_pkg::FUNC_ALLOC;
    r.size_bytes = bytes_of(pick_blocks());
    r.offset_in  = bpa_pkg::OFF_W'($urandom);
    if (p >= 40 && p < 70 && live_first.size() != 0) begin
      // Release a live region, most often the newest one at the bump index.
      idx = ($urandom_range(0, 99) < 60) ? live_first.size() - 1
                                         : $urandom_range(0, live_first.size() - 1);
      r.func       = bpa_pkg::FUNC_FREE;
      r.size_bytes = bytes_of(live_count[idx]);
      r.offset_in  = bpa_pkg::OFF_W'(live_first[idx] * bb);
      if ($urandom_range(0, 9) == 0) begin
        r.offset_in = bpa_pkg::OFF_W'(live_first[idx] * bb + $urandom_range(0, bb - 1));
      end
      live_first.delete(idx);
      live_count.delete(idx);
    end else if (p >= 70 && p < 80) begin
      r.func = bpa_pkg::FUNC_PROBE;
    end else if (p >= 80 && p < 88) begin
      r.func      = bpa_pkg::FUNC_OWN;
      r.offset_in = ($urandom_range(0, 1) == 0) ? bpa_pkg::OFF_W'($urandom)
                    : bpa_pkg::OFF_W'($urandom_range(0, 2 * bpa_pkg::POOL_BLOCKS * bb));
    end else if (p >= 88) begin
      // Unstructured request: any operation, any size and offset.
      r.func       = bpa_pkg::func_e'($urandom_range(0, 3));
      r.size_bytes = ($urandom_range(0, 3) == 0) ? '0
                     : bpa_pkg::SIZE_W'($urandom_range(0, 1048576));
      r.offset_in  = ($urandom_range(0, 1) == 0) ? bpa_pkg::OFF_W'($urandom)
                     : bpa_pkg::OFF_W'($urandom_range(0, bpa_pkg::POOL_BLOCKS * bb));
    end
    send_request(r);
  endtask

  // Stimulus: directed corner cases at the reset block size, then random phases.
  initial begin
    logic [bpa_pkg::BB_W-1:0] phase_bb[10];
    int                       p;
    phase_bb    = '{13'd1, 13'd8191, 13'd0, 13'd4096, 13'd4097,
                    13'd3, 13'd24, 13'd8, 13'd100, 13'd1000};
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    quiet       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed(bpa_pkg::FUNC_ALLOC, 0, 0);
    directed(bpa_pkg::FUNC_PROBE, 0, 0);
    directed(bpa_pkg::FUNC_FREE, 0, 0);
    directed(bpa_pkg::FUNC_ALLOC, 1048576, 0);
    directed(bpa_pkg::FUNC_PROBE, 2049, 0);
    directed(bpa_pkg::FUNC_PROBE, 2048, 0);
    // Fill the pool, then open a hole just below the bump index.
    directed(bpa_pkg::FUNC_ALLOC, 2048, 0);
    directed(bpa_pkg::FUNC_ALLOC, 1, 0);
    directed(bpa_pkg::FUNC_PROBE, 1, 0);
    directed(bpa_pkg::FUNC_FREE, 8, 2000);
    directed(bpa_pkg::FUNC_FREE, 40, 2008);
    directed(bpa_pkg::FUNC_ALLOC, 56, 0);
    // Bump path runs off the pool end, so first fit takes the hole.
    directed(bpa_pkg::FUNC_ALLOC, 41, 0);
    directed(bpa_pkg::FUNC_FREE, 1, 2000);
    directed(bpa_pkg::FUNC_FREE, 16, 0);
    // The block above the bump index is in use: first fit again.
    directed(bpa_pkg::FUNC_ALLOC, 16, 1048575);
    directed(bpa_pkg::FUNC_FREE, 8, 1048575);
    directed(bpa_pkg::FUNC_FREE, 16, 2040);
    directed(bpa_pkg::FUNC_FREE, 8, 5);
    directed(bpa_pkg::FUNC_FREE, 8, 5);
    directed(bpa_pkg::FUNC_OWN, 0, 0);
    directed(bpa_pkg::FUNC_OWN, 1048576, 2047);
    directed(bpa_pkg::FUNC_OWN, 0, 2048);
    directed(bpa_pkg::FUNC_OWN, 0, 1048575);
    directed(bpa_pkg::FUNC_FREE, 2048, 0);
    drain();

    for (p = 0; p < 10; p++) begin
      write_block_bytes(phase_bb[p]);
      quiet = (p == 3 || p == 4);
      repeat (93) begin
        random_request();
        sender_gap();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit well above the slowest correct run.
  initial begin
    #10000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
